@@ hdl/bcfrf_pkg.sv @@
// Shared types and constants of the fold range finder.
package bcfrf_pkg;

    localparam int STACK_DEPTH = 32;
    localparam int LINE_BITS   = 16;
    localparam int OUT_LINE_W  = 16;
    localparam int QUEUE_DEPTH = 4;

    localparam int STACK_IDX_W = $clog2(STACK_DEPTH);
    localparam int STACK_CNT_W = $clog2(STACK_DEPTH + 1);
    localparam int QUEUE_IDX_W = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

    localparam logic [LINE_BITS-1:0] LINE_MAX = '1;

    localparam logic [7:0] CH_NEWLINE = 8'h0A;
    localparam logic [7:0] CH_SLASH   = 8'h2F;
    localparam logic [7:0] CH_STAR    = 8'h2A;
    localparam logic [7:0] CH_LBRACE  = 8'h7B;
    localparam logic [7:0] CH_RBRACE  = 8'h7D;

    typedef enum logic [1:0] {
        OP_NONE,
        OP_PUSH,
        OP_POP_COMMENT,
        OP_POP_BRACE
    } t_op;

    typedef struct packed {
        logic [7:0] text_byte;
        logic       text_start;
    } t_in_item;

    typedef struct packed {
        logic [OUT_LINE_W-1:0] start_line;
        logic [OUT_LINE_W-1:0] end_line;
        logic                  comment_range;
        logic                  overflowed;
    } t_out_item;

    // One stack operation handed from the classifier to the stack engine.
    typedef struct packed {
        t_op                  op;
        logic                 clear;
        logic [LINE_BITS-1:0] line;
    } t_stack_op;

    function automatic logic [OUT_LINE_W-1:0] to_out_line(input logic [LINE_BITS-1:0] line);
        return OUT_LINE_W'(line);
    endfunction

endpackage

@@ hdl/brace_comment_fold_range_finder_core.sv @@
// Top level of the fold range finder: classifier, operation queue, stack engine.
//
// Usage: source text enters one byte per transaction on the input channel
// (i_in_valid, o_in_ready, i_in_data). Set text_start on the first byte of a
// new text; all line, comment and stack state is cleared before that byte.
// Each closed block comment, and each brace pair that spans lines, yields one
// transaction on the output channel (o_out_valid, i_out_ready, o_out_data)
// with the opening line, the closing line, the kind of range and the sticky
// overflow flag of the current text.
// Throughput is one byte per cycle while o_in_ready is high. The classifier
// handles a byte in the cycle it is accepted; stack work is a single push
// or pop per cycle in the stack engine, whose memory read for a pop is
// registered. A closing byte's operation goes through the queue, the pop
// read stage and the output register before o_out_valid rises.
// When the receiver stalls, the output register holds its transaction and
// the stack engine stops; the four-entry operation queue keeps absorbing
// bytes until it is full, then o_in_ready drops. Bytes that cause no stack
// work and start no text never enter the queue.
// Reset (synchronous, active low) empties the queue and the stack and clears
// the line counter, comment mode and overflow flag. The stack memory itself
// is not cleared; only entries written since the text start are read.
module brace_comment_fold_range_finder_core (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  bcfrf_pkg::t_in_item  i_in_data,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output bcfrf_pkg::t_out_item o_out_data
);

    // Operations leaving the classifier.
    logic                 front_valid;
    logic                 front_ready;
    bcfrf_pkg::t_stack_op front_op;

    // Operations leaving the queue toward the stack engine.
    logic                 back_valid;
    logic                 back_ready;
    bcfrf_pkg::t_stack_op back_op;

    bcfrf_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_in_valid),
        .o_ready    (o_in_ready),
        .i_data     (i_in_data),
        .o_op_valid (front_valid),
        .i_op_ready (front_ready),
        .o_op       (front_op)
    );

    bcfrf_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (front_valid),
        .o_ready (front_ready),
        .i_data  (front_op),
        .o_valid (back_valid),
        .i_ready (back_ready),
        .o_data  (back_op)
    );

    bcfrf_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_op_valid (back_valid),
        .o_op_ready (back_ready),
        .i_op       (back_op),
        .o_valid    (o_out_valid),
        .i_ready    (i_out_ready),
        .o_data     (o_out_data)
    );

endmodule

@@ hdl/bcfrf_front.sv @@
// Character classifier: tracks lines, comment mode and pending characters.
module bcfrf_front (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    output logic                  o_ready,
    input  bcfrf_pkg::t_in_item   i_data,
    output logic                  o_op_valid,
    input  logic                  i_op_ready,
    output bcfrf_pkg::t_stack_op  o_op
);

    logic [bcfrf_pkg::LINE_BITS-1:0] r_line, n_line, cur_line;
    logic r_in_comment, n_in_comment, cur_in_comment;
    logic r_slash, n_slash, cur_slash;
    logic r_star, n_star, cur_star;
    bcfrf_pkg::t_op op;
    logic accept;

    always_comb begin
        // A text start clears all state before the byte is looked at.
        cur_line       = i_data.text_start ? '0 : r_line;
        cur_in_comment = i_data.text_start ? 1'b0 : r_in_comment;
        cur_slash      = i_data.text_start ? 1'b0 : r_slash;
        cur_star       = i_data.text_start ? 1'b0 : r_star;

        n_line       = cur_line;
        n_in_comment = cur_in_comment;
        n_slash      = 1'b0;
        n_star       = 1'b0;
        op           = bcfrf_pkg::OP_NONE;

        if (cur_slash && i_data.text_byte == bcfrf_pkg::CH_STAR) begin
            op           = bcfrf_pkg::OP_PUSH;
            n_in_comment = 1'b1;
        end else if (cur_star && cur_in_comment && i_data.text_byte == bcfrf_pkg::CH_SLASH) begin
            op           = bcfrf_pkg::OP_POP_COMMENT;
            n_in_comment = 1'b0;
        end else begin
            case (i_data.text_byte)
                bcfrf_pkg::CH_NEWLINE: begin
                    if (cur_line != bcfrf_pkg::LINE_MAX) begin
                        n_line = cur_line + 1'b1;
                    end
                end
                bcfrf_pkg::CH_SLASH:  n_slash = 1'b1;
                bcfrf_pkg::CH_STAR:   n_star  = cur_in_comment;
                bcfrf_pkg::CH_LBRACE: begin
                    if (!cur_in_comment) begin
                        op = bcfrf_pkg::OP_PUSH;
                    end
                end
                bcfrf_pkg::CH_RBRACE: begin
                    if (!cur_in_comment) begin
                        op = bcfrf_pkg::OP_POP_BRACE;
                    end
                end
                default: ;
            endcase
        end
    end

    assign o_ready    = i_op_ready;
    assign accept     = i_valid && i_op_ready;
    // A text start always reaches the stack engine so that it clears too.
    assign o_op_valid = i_valid && (op != bcfrf_pkg::OP_NONE || i_data.text_start);
    assign o_op.op    = op;
    assign o_op.clear = i_data.text_start;
    assign o_op.line  = cur_line;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_line       <= '0;
            r_in_comment <= 1'b0;
            r_slash      <= 1'b0;
            r_star       <= 1'b0;
        end else if (accept) begin
            r_line       <= n_line;
            r_in_comment <= n_in_comment;
            r_slash      <= n_slash;
            r_star       <= n_star;
        end
    end

endmodule

@@ hdl/bcfrf_queue.sv @@
// Small queue of stack operations between the classifier and the stack engine.
module bcfrf_queue (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_ready,
    input  bcfrf_pkg::t_stack_op i_data,
    output logic                 o_valid,
    input  logic                 i_ready,
    output bcfrf_pkg::t_stack_op o_data
);

    bcfrf_pkg::t_stack_op r_mem [bcfrf_pkg::QUEUE_DEPTH];
    logic [bcfrf_pkg::QUEUE_IDX_W-1:0] r_wp, r_rp;
    logic [bcfrf_pkg::QUEUE_CNT_W-1:0] r_cnt;
    logic push, pop;

    assign o_ready = r_cnt != bcfrf_pkg::QUEUE_CNT_W'(bcfrf_pkg::QUEUE_DEPTH);
    assign o_valid = r_cnt != '0;
    assign o_data  = r_mem[r_rp];
    assign push    = i_valid && o_ready;
    assign pop     = o_valid && i_ready;

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wp] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (push) begin
                r_wp <= (r_wp == bcfrf_pkg::QUEUE_IDX_W'(bcfrf_pkg::QUEUE_DEPTH - 1))
                        ? '0 : r_wp + 1'b1;
            end
            if (pop) begin
                r_rp <= (r_rp == bcfrf_pkg::QUEUE_IDX_W'(bcfrf_pkg::QUEUE_DEPTH - 1))
                        ? '0 : r_rp + 1'b1;
            end
            case ({push, pop})
                2'b10:   r_cnt <= r_cnt + 1'b1;
                2'b01:   r_cnt <= r_cnt - 1'b1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

endmodule

@@ hdl/bcfrf_back.sv @@
// Stack engine: line stack in memory, pop read stage and output register.
module bcfrf_back (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_op_valid,
    output logic                 o_op_ready,
    input  bcfrf_pkg::t_stack_op i_op,
    output logic                 o_valid,
    input  logic                 i_ready,
    output bcfrf_pkg::t_out_item o_data
);

    logic [bcfrf_pkg::LINE_BITS-1:0] r_stack [bcfrf_pkg::STACK_DEPTH];
    logic [bcfrf_pkg::LINE_BITS-1:0] r_rd_line;
    logic [bcfrf_pkg::STACK_CNT_W-1:0] r_cnt, n_cnt, cur_cnt, cnt_dec;
    logic r_ovf, n_ovf, cur_ovf;

    logic                            r_b_valid;
    logic                            r_b_comment;
    logic                            r_b_ovf;
    logic [bcfrf_pkg::LINE_BITS-1:0] r_b_end;

    logic                 r_o_valid;
    bcfrf_pkg::t_out_item r_o_data;

    logic free, a_adv, do_push, do_pop, emit;

    // Every stage moves together whenever the output register can take a value.
    assign free       = !r_o_valid || i_ready;
    assign o_op_ready = free;
    assign a_adv      = i_op_valid && free;

    assign cur_cnt = i_op.clear ? '0 : r_cnt;
    assign cur_ovf = i_op.clear ? 1'b0 : r_ovf;
    assign cnt_dec = cur_cnt - 1'b1;
    assign do_push = a_adv && i_op.op == bcfrf_pkg::OP_PUSH
                     && cur_cnt != bcfrf_pkg::STACK_CNT_W'(bcfrf_pkg::STACK_DEPTH);
    assign do_pop  = a_adv && (i_op.op == bcfrf_pkg::OP_POP_COMMENT
                     || i_op.op == bcfrf_pkg::OP_POP_BRACE) && cur_cnt != '0;

    always_comb begin
        n_cnt = cur_cnt;
        n_ovf = cur_ovf;
        if (do_push) begin
            n_cnt = cur_cnt + 1'b1;
        end else if (do_pop) begin
            n_cnt = cnt_dec;
        end else if (i_op.op == bcfrf_pkg::OP_PUSH) begin
            n_ovf = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_stack[cur_cnt[bcfrf_pkg::STACK_IDX_W-1:0]] <= i_op.line;
        end
        if (do_pop) begin
            r_rd_line <= r_stack[cnt_dec[bcfrf_pkg::STACK_IDX_W-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (a_adv) begin
            r_b_comment <= i_op.op == bcfrf_pkg::OP_POP_COMMENT;
            r_b_ovf     <= n_ovf;
            r_b_end     <= i_op.line;
        end
    end

    // A brace range counts only when it spans lines; a comment range always does.
    assign emit = r_b_valid && (r_b_comment || r_b_end > r_rd_line);

    always_ff @(posedge i_clk) begin
        if (free && emit) begin
            r_o_data.start_line    <= bcfrf_pkg::to_out_line(r_rd_line);
            r_o_data.end_line      <= bcfrf_pkg::to_out_line(r_b_end);
            r_o_data.comment_range <= r_b_comment;
            r_o_data.overflowed    <= r_b_ovf;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt     <= '0;
            r_ovf     <= 1'b0;
            r_b_valid <= 1'b0;
            r_o_valid <= 1'b0;
        end else if (free) begin
            if (a_adv) begin
                r_cnt <= n_cnt;
                r_ovf <= n_ovf;
            end
            r_b_valid <= do_pop;
            r_o_valid <= emit;
        end
    end

    assign o_valid = r_o_valid;
    assign o_data  = r_o_data;

    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= bcfrf_pkg::STACK_CNT_W'(bcfrf_pkg::STACK_DEPTH))
        else $error("stack count above depth");

    a_push_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (do_push && !i_op.clear) |=> (r_cnt == $past(r_cnt) + 1'b1))
        else $error("push did not grow the stack");

    a_ovf_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ovf && !(a_adv && i_op.clear)) |=> r_ovf)
        else $error("overflow flag dropped without text start");

    a_pop_feeds_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_b_valid && r_b_comment && free) |=> o_valid)
        else $error("comment close lost");

endmodule

@@ verif/testbench.sv @@
// Self-checking testbench of the fold range finder core: byte stream in, fold ranges out.
`timescale 1ns / 1ps

module testbench;

    // Cycles without any transaction before the run is declared hung. The longest
    // legal quiet spell comes from the receiver hold-off below.
    localparam int WATCHDOG_LIMIT = 2000;
    // Receiver hold-off: starts at this cycle after reset and lasts this many cycles.
    localparam int HOLD_FIRST_CYCLE = 80;
    localparam int HOLD_CYCLES = 300;
    // Stretch of clock cycles in which neither side idles.
    localparam int CALM_FIRST_CYCLE = 420;
    localparam int CALM_LAST_CYCLE = 620;
    // Input transactions wanted for the whole run.
    localparam int TOTAL_BYTES = 500;
    // Cycles allowed after the last expected range for stray output.
    localparam int SETTLE_CYCLES = 20;
    localparam int IDLE_PERCENT = 17;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_ready;
    bcfrf_pkg::t_in_item in_data = '0;
    logic out_valid;
    logic out_ready = 1'b0;
    bcfrf_pkg::t_out_item out_data;

    // Bytes waiting to be offered, and fold ranges predicted but not yet seen.
    bcfrf_pkg::t_in_item text_bytes[$];
    bcfrf_pkg::t_out_item expected_ranges[$];

    // Scanner state mirrored by the predictor.
    logic [bcfrf_pkg::LINE_BITS-1:0] open_lines[bcfrf_pkg::STACK_DEPTH];
    int unsigned open_depth = 0;
    logic [bcfrf_pkg::LINE_BITS-1:0] cur_line = '0;
    logic in_comment = 1'b0;
    logic saw_slash = 1'b0;
    logic saw_star = 1'b0;
    logic dropped_push = 1'b0;

    // Stimulus bookkeeping.
    logic starts_text = 1'b0;

    int unsigned errors = 0;
    int unsigned cycle_count = 0;
    int unsigned hold_left = 0;
    int unsigned quiet_cycles = 0;
    bcfrf_pkg::t_out_item oldest_range;

    brace_comment_fold_range_finder_core i_dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_data  (out_data)
    );

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Predictor of the scanner
    // ------------------------------------------------------------------

    // A push onto a full stack is lost; the text remembers that it happened.
    function automatic void push_open();
        if (open_depth < bcfrf_pkg::STACK_DEPTH) begin
            open_lines[open_depth] = cur_line;
            open_depth++;
        end else begin
            dropped_push = 1'b1;
        end
    endfunction

    function automatic bit pop_open(output logic [bcfrf_pkg::LINE_BITS-1:0] popped);
        popped = '0;
        if (open_depth == 0) begin
            return 1'b0;
        end
        open_depth--;
        popped = open_lines[open_depth];
        return 1'b1;
    endfunction

    function automatic void expect_range(logic [bcfrf_pkg::LINE_BITS-1:0] from_line,
                                         logic is_comment);
        bcfrf_pkg::t_out_item range;
        range.start_line = bcfrf_pkg::OUT_LINE_W'(from_line);
        range.end_line = bcfrf_pkg::OUT_LINE_W'(cur_line);
        range.comment_range = is_comment;
        range.overflowed = dropped_push;
        expected_ranges = {expected_ranges, range};
    endfunction

    // Advances the mirrored scanner by one accepted byte and queues the fold
    // range that the byte closes, if any.
    function automatic void scan_byte(bcfrf_pkg::t_in_item item);
        logic [bcfrf_pkg::LINE_BITS-1:0] opened;
        if (item.text_start) begin
            open_depth = 0;
            cur_line = '0;
            in_comment = 1'b0;
            saw_slash = 1'b0;
            saw_star = 1'b0;
            dropped_push = 1'b0;
        end
        if (saw_slash && item.text_byte == bcfrf_pkg::CH_STAR) begin
            // Comment opening, nested or not; both characters are consumed.
            saw_slash = 1'b0;
            saw_star = 1'b0;
            push_open();
            in_comment = 1'b1;
        end else if (saw_star && in_comment && item.text_byte == bcfrf_pkg::CH_SLASH) begin
            // Comment close: leaves comment mode even if an outer opening remains.
            saw_slash = 1'b0;
            saw_star = 1'b0;
            in_comment = 1'b0;
            if (pop_open(opened)) begin
                expect_range(opened, 1'b1);
            end
        end else begin
            saw_slash = 1'b0;
            saw_star = 1'b0;
            case (item.text_byte)
                bcfrf_pkg::CH_NEWLINE: begin
                    if (cur_line != bcfrf_pkg::LINE_MAX) begin
                        cur_line++;
                    end
                end
                bcfrf_pkg::CH_SLASH: saw_slash = 1'b1;
                bcfrf_pkg::CH_STAR: saw_star = in_comment;
                bcfrf_pkg::CH_LBRACE: begin
                    if (!in_comment) begin
                        push_open();
                    end
                end
                bcfrf_pkg::CH_RBRACE: begin
                    // Braces closing on the line they opened on give no fold range.
                    if (!in_comment) begin
                        if (pop_open(opened)) begin
                            if (cur_line > opened) begin
                                expect_range(opened, 1'b0);
                            end
                        end
                    end
                end
                default: ;
            endcase
        end
    endfunction

    // ------------------------------------------------------------------
    // Stimulus construction
    // ------------------------------------------------------------------

    function automatic void add_byte(logic [7:0] value);
        bcfrf_pkg::t_in_item item;
        item.text_byte = value;
        item.text_start = starts_text;
        starts_text = 1'b0;
        text_bytes = {text_bytes, item};
    endfunction

    function automatic void add_text(string chars);
        for (int k = 0; k < chars.len(); k++) begin
            add_byte(chars[k]);
        end
    endfunction

    // One random text: mostly braces, comment tokens and newlines, with some
    // stray stars, slashes and arbitrary bytes. A deep text first nests braces
    // up to around the stack depth so that overflow and full-stack comments can occur.
    function automatic void add_random_text(bit deep);
        int unsigned pick;
        starts_text = 1'b1;
        if (deep) begin
            repeat ($urandom_range(28, 40)) begin
                add_byte(bcfrf_pkg::CH_LBRACE);
                if ($urandom_range(0, 3) == 0) begin
                    add_byte(bcfrf_pkg::CH_NEWLINE);
                end
            end
        end
        repeat ($urandom_range(4, 40)) begin
            pick = $urandom_range(0, 99);
            if (pick < 22) begin
                add_byte(bcfrf_pkg::CH_LBRACE);
            end else if (pick < 40) begin
                add_byte(bcfrf_pkg::CH_RBRACE);
            end else if (pick < 58) begin
                add_byte(bcfrf_pkg::CH_NEWLINE);
            end else if (pick < 66) begin
                add_text("/*");
            end else if (pick < 74) begin
                add_text("*/");
            end else if (pick < 80) begin
                add_byte(bcfrf_pkg::CH_STAR);
            end else if (pick < 84) begin
                add_byte(bcfrf_pkg::CH_SLASH);
            end else begin
                add_byte(8'($urandom_range(0, 255)));
            end
        end
    endfunction

    function automatic bit in_calm_window();
        return (cycle_count >= CALM_FIRST_CYCLE) && (cycle_count < CALM_LAST_CYCLE);
    endfunction

    // ------------------------------------------------------------------
    // Cycle counter and the receiver's long hold-off.
    // ------------------------------------------------------------------
    always @(posedge clk) begin
        if (!rst_n) begin
            cycle_count <= 0;
            hold_left <= 0;
        end else begin
            cycle_count <= cycle_count + 1;
            if (cycle_count == HOLD_FIRST_CYCLE) begin
                hold_left <= HOLD_CYCLES;
            end else if (hold_left > 0) begin
                hold_left <= hold_left - 1;
            end
        end
    end

    // ------------------------------------------------------------------
    // Driver: offers queued bytes and predicts on every accepted transaction.
    // ------------------------------------------------------------------
    always @(posedge clk) begin
        if (!rst_n) begin
            in_valid <= 1'b0;
        end else begin
            if (in_valid && in_ready) begin
                scan_byte(in_data);
            end
            // A new byte may only go out once the current one is taken.
            if (!in_valid || in_ready) begin
                if (text_bytes.size() > 0 &&
                    (in_calm_window() || $urandom_range(0, 99) >= IDLE_PERCENT)) begin
                    in_data <= text_bytes.pop_front();
                    in_valid <= 1'b1;
                end else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Monitor: checks every output transaction against the oldest prediction
    // and drives the receiver's ready. During the hold-off the sender keeps
    // offering, so the operation queue fills and the input side has to stall.
    // ------------------------------------------------------------------
    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        $display("ERROR at %0t: %s got %0d, expected %0d", $time, what, got, want);
        errors++;
    endtask

    always @(posedge clk) begin
        if (!rst_n) begin
            out_ready <= 1'b0;
        end else begin
            if (out_valid && out_ready) begin
                if (expected_ranges.size() == 0) begin
                    report_mismatch("unexpected range, start_line",
                                    32'(out_data.start_line), 32'd0);
                end else begin
                    oldest_range = expected_ranges.pop_front();
                    if (out_data.start_line !== oldest_range.start_line) begin
                        report_mismatch("start_line", 32'(out_data.start_line),
                                        32'(oldest_range.start_line));
                    end
                    if (out_data.end_line !== oldest_range.end_line) begin
                        report_mismatch("end_line", 32'(out_data.end_line),
                                        32'(oldest_range.end_line));
                    end
                    if (out_data.comment_range !== oldest_range.comment_range) begin
                        report_mismatch("comment_range", 32'(out_data.comment_range),
                                        32'(oldest_range.comment_range));
                    end
                    if (out_data.overflowed !== oldest_range.overflowed) begin
                        report_mismatch("overflowed", 32'(out_data.overflowed),
                                        32'(oldest_range.overflowed));
                    end
                end
            end
            if (hold_left > 0) begin
                out_ready <= 1'b0;
            end else begin
                out_ready <= in_calm_window() || $urandom_range(0, 99) >= IDLE_PERCENT;
            end
        end
    end

    // ------------------------------------------------------------------
    // Watchdog: a run with no transaction for too long has hung.
    // ------------------------------------------------------------------
    always @(posedge clk) begin
        if (rst_n) begin
            if ((in_valid && in_ready) || (out_valid && out_ready)) begin
                quiet_cycles = 0;
            end else begin
                quiet_cycles++;
            end
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("Watchdog: no transaction for %0d cycles", WATCHDOG_LIMIT);
                $display("SCOREBOARD MISMATCH");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------
    initial begin
        // Directed texts. The first covers a brace pair across lines, a pair
        // on one line, a close brace on an empty stack and a one-line comment.
        starts_text = 1'b1;
        add_text("{\n}{}}/**/");
        // Nested comment: the inner close ends comment mode and leaves the
        // outer opening on the stack.
        add_text("/*/*\n*/");
        // A comment close outside a comment does nothing, but its slash still
        // starts an opening; the brace then pops the leftover comment opening.
        add_text("*/*\n*/}");
        // A slash pending at the end of a text is dropped by the next text start.
        add_byte(bcfrf_pkg::CH_SLASH);
        starts_text = 1'b1;
        add_text("*\n}");
        add_byte(8'h00);
        add_byte(8'hFF);

        // Random texts, about one in five nesting braces around the stack depth.
        while (text_bytes.size() < TOTAL_BYTES) begin
            add_random_text($urandom_range(0, 4) == 0);
        end

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        while (text_bytes.size() > 0 || in_valid || expected_ranges.size() > 0) begin
            @(posedge clk);
        end
        repeat (SETTLE_CYCLES) @(posedge clk);

        if (errors == 0 && expected_ranges.size() == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule

@@ sim.f @@
hdl/bcfrf_pkg.sv
hdl/bcfrf_front.sv
hdl/bcfrf_queue.sv
hdl/bcfrf_back.sv
hdl/brace_comment_fold_range_finder_core.sv
verif/testbench.sv
